>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the pooling block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Types and constants shared by the segment max pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smp_pkg;

  // Default sizing of the entry store.
  localparam int SEGMENTS_DEF    = 32;
  localparam int CHANNELS_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  // Fixed field widths of the channels and registers.
  localparam int INDEX_WIDTH   = 8;
  localparam int FEATURE_WIDTH = 16;
  localparam int COUNT_WIDTH   = 6;
  localparam int LIMIT_WIDTH   = 9;
  localparam int ADDR_CALC_W   = 17;

  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 6'd32;

  // Operation carried by an input transaction.
  typedef enum logic {
    MODE_ACCUMULATE = 1'b0,
    MODE_READ       = 1'b1
  } mode_t;

  // Status reported with every result transaction.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_SEGMENT = 2'd1,
    ERR_CHANNEL = 2'd2
  } err_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SEGMENT_COUNT = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

endpackage

>>> hdl/smp_if.sv
// ----------------------------------------------------------------------------
// smp_in_if / smp_out_if
// Valid-ready channels for input items and pooling results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smp_in_if;
  logic                                         valid;
  logic                                         ready;
  smp_pkg::mode_t                               mode;
  logic        [smp_pkg::INDEX_WIDTH-1:0]       segment_index;
  logic        [smp_pkg::INDEX_WIDTH-1:0]       channel;
  logic signed [smp_pkg::FEATURE_WIDTH-1:0]     feature_value;

  modport source (output valid, mode, segment_index, channel, feature_value,
                  input ready);
  modport sink   (input valid, mode, segment_index, channel, feature_value,
                  output ready);
endinterface

interface smp_out_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [smp_pkg::FEATURE_WIDTH-1:0]     pooled_value;
  logic                                         read_valid;
  smp_pkg::err_t                                error;

  modport source (output valid, pooled_value, read_valid, error, input ready);
  modport sink   (input valid, pooled_value, read_valid, error, output ready);
endinterface

>>> hdl/smp_ram.sv
// ----------------------------------------------------------------------------
// smp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; returns the old word on a same-address write.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/segment_max_pool.sv
// Pipeline: an input is registered in stage one and then in the output register.
// Throughput: one transaction per cycle unless result ready stalls, set by the single read-modify-write
// of the entry RAM per item, with the last write forwarded to the next item.
// Reset: counts return to 32 and a clearing pass writes every entry of the
// RAM once, SEGMENTS*CHANNELS entries (1024 by default), with item ready low.
// ----------------------------------------------------------------------------
// segment_max_pool
// Scatter-max pooling of Q8.8 point features into (segment, channel) entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module segment_max_pool #(
  parameter int SEGMENTS    = smp_pkg::SEGMENTS_DEF,
  parameter int CHANNELS    = smp_pkg::CHANNELS_DEF,
  parameter int VALUE_WIDTH = smp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [smp_pkg::COUNT_WIDTH-1:0] cfg_data,
  smp_in_if.sink                          item,
  smp_out_if.source                       result
);

  localparam int ENTRIES = SEGMENTS * CHANNELS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int VW      = VALUE_WIDTH;
  localparam int FW      = smp_pkg::FEATURE_WIDTH;
  localparam int LW      = smp_pkg::LIMIT_WIDTH;
  localparam int CW      = smp_pkg::ADDR_CALC_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  // Configuration registers.
  logic [smp_pkg::COUNT_WIDTH-1:0] segment_count;
  logic [smp_pkg::COUNT_WIDTH-1:0] channel_count;

  // Clearing pass.
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // Stage one: item waiting for its RAM word.
  logic                 s1_valid;
  smp_pkg::mode_t       s1_mode;
  smp_pkg::err_t        s1_err;
  logic [AW-1:0]        s1_addr;
  logic signed [VW-1:0] s1_val;
  logic                 s1_fire;

  // Forwarding of the most recent item write.
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [VW:0]   fwd_data;

  // Output register.
  logic                 out_valid;
  logic signed [FW-1:0] out_pooled;
  logic                 out_read_valid;
  smp_pkg::err_t        out_error;

  // RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW:0]   ram_wdata;
  logic [VW:0]   ram_rdata;

  // Stage zero decode.
  logic                 in_fire;
  logic [LW-1:0]        seg_lim;
  logic [LW-1:0]        ch_lim;
  smp_pkg::err_t        in_err;
  logic [CW-1:0]        addr_full;
  logic [VW+FW-1:0]     val_ext;

  // Stage one update.
  logic [VW:0]          cur_word;
  logic                 cur_valid;
  logic signed [VW-1:0] cur_val;
  logic signed [VW-1:0] new_val;
  logic [VW:0]          new_word;
  logic signed [VW-1:0] read_val;
  logic [VW+FW-1:0]     read_ext;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      segment_count <= smp_pkg::COUNT_RESET;
      channel_count <= smp_pkg::COUNT_RESET;
    end else if (cfg_write) begin
      case (smp_pkg::cfg_reg_t'(cfg_index))
        smp_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data;
        smp_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass over every entry after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Handshake: stage one advances when the output register is free or drained.
  assign s1_fire    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !clr_busy && (!s1_valid || s1_fire);
  assign in_fire    = item.valid && item.ready;

  // Range checks against the effective counts, and the entry address.
  always_comb begin
    seg_lim = (LW'(segment_count) > LW'(SEGMENTS)) ? LW'(SEGMENTS) : LW'(segment_count);
    ch_lim  = (LW'(channel_count) > LW'(CHANNELS)) ? LW'(CHANNELS) : LW'(channel_count);
    if (LW'(item.segment_index) >= seg_lim) begin
      in_err = smp_pkg::ERR_SEGMENT;
    end else if (LW'(item.channel) >= ch_lim) begin
      in_err = smp_pkg::ERR_CHANNEL;
    end else begin
      in_err = smp_pkg::ERR_NONE;
    end
    addr_full = CW'(item.segment_index) * CW'(CHANNELS) + CW'(item.channel);
    val_ext   = {{VW{1'b0}}, item.feature_value};
  end

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode <= item.mode;
      s1_err  <= in_err;
      s1_addr <= addr_full[AW-1:0];
      s1_val  <= val_ext[VW-1:0];
    end
  end

  // Current entry, with the previous write forwarded past the RAM.
  always_comb begin
    cur_word  = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
    cur_valid = cur_word[VW];
    cur_val   = cur_word[VW-1:0];
    new_val   = (!cur_valid || s1_val > cur_val) ? s1_val : cur_val;
    if (s1_mode == smp_pkg::MODE_READ) begin
      new_word = '0;
    end else begin
      new_word = {1'b1, new_val};
    end
    read_val = cur_valid ? cur_val : '0;
    // The stored bits are reported as they are, without sign extension.
    read_ext = {{FW{1'b0}}, read_val};
  end

  // RAM write: clearing pass first, then item write-back.
  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire && (s1_err == smp_pkg::ERR_NONE);
      ram_waddr = s1_addr;
      ram_wdata = new_word;
    end
  end

  // Forwarding register follows every item write.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (!clr_busy && ram_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!clr_busy && ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  smp_ram #(
    .WIDTH (VW + 1),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (addr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_error <= s1_err;
      if (s1_err == smp_pkg::ERR_NONE && s1_mode == smp_pkg::MODE_READ) begin
        out_pooled     <= read_ext[FW-1:0];
        out_read_valid <= 1'b1;
      end else begin
        out_pooled     <= '0;
        out_read_valid <= 1'b0;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.pooled_value = out_pooled;
  assign result.read_valid   = out_read_valid;
  assign result.error        = out_error;

  // No item enters while the clearing pass still owns the RAM.
  `ASSERT_IMPLIES(a_no_accept_in_clear, clk, rst, clr_busy, !item.ready, "item accepted during clear")
  // A flagged item leaves the store untouched.
  `ASSERT_IMPLIES(a_err_no_write, clk, rst, !clr_busy && s1_valid && s1_err != smp_pkg::ERR_NONE, !ram_we, "flagged item wrote the store")
  // A read result is only reported for an in-range item.
  `ASSERT_IMPLIES(a_read_ok, clk, rst, result.valid && result.read_valid, result.error == smp_pkg::ERR_NONE, "read result with error")
  // The clearing pass ends after the last entry.
  `ASSERT_NEXT(a_clear_ends, clk, rst, clr_busy && clr_addr == LAST_ADDR, !clr_busy, "clearing pass did not end")

endmodule
